// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define QPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qpr assertion failed");

// next-cycle implication, held off while reset is asserted
`define QPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qpr assertion failed");

`endif

// ===== rtl/qpr_pkg.sv =====
// types and constants of the quaternion point rotator
package qpr_pkg;

    // coordinate format of points in and out
    localparam int COORD_WIDTH = 24;

    // quaternion register format as written over the bus
    localparam int QUAT_WIDTH = 16;

    // configuration bus
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_QUAT_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_QUAT_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_QUAT_Z = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_QUAT_W = 2'd3;

    // input beat: one point
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } pt_beat_t;

    // output beat: rotated point and saturation flag
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rot_x;
        logic signed [COORD_WIDTH-1:0] rot_y;
        logic signed [COORD_WIDTH-1:0] rot_z;
        logic                          clipped;
    } rot_beat_t;

endpackage

// ===== rtl/quaternion_point_rotator_unit.sv =====
// quaternion point rotator top level
// a taken point passes the input, product and result registers in turn to reach the result port
// throughput: one point per cycle, every stage moves each cycle while the result is not stalled
// a quaternion write is loaded into the rotation matrix register at the edge after the write edge
// reset: quaternion (0, 0, 0, 1), identity matrix, pipeline empty
module quaternion_point_rotator_unit
    import qpr_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = 14
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  pt_valid,
    output logic                  pt_stall,
    input  pt_beat_t              pt_beat,
    output logic                  rot_valid,
    input  logic                  rot_stall,
    output rot_beat_t             rot_beat
);

    logic signed [QUAT_FRAC_BITS+3:0] matrix [9];

    // bus never waits
    assign pready = 1'b1;

    // quaternion registers and matrix
    qpr_matrix #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .matrix  (matrix)
    );

    // point pipeline
    qpr_datapath #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .matrix    (matrix),
        .pt_valid  (pt_valid),
        .pt_stall  (pt_stall),
        .pt_beat   (pt_beat),
        .rot_valid (rot_valid),
        .rot_stall (rot_stall),
        .rot_beat  (rot_beat)
    );

endmodule

// ===== rtl/qpr_matrix.sv =====
// quaternion registers and rotation matrix builder
module qpr_matrix
    import qpr_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = 14
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [APB_ADDR_W-1:0]                  paddr,
    input  logic [APB_DATA_W-1:0]                  pwdata,
    output logic [APB_DATA_W-1:0]                  prdata,
    output logic signed [QUAT_FRAC_BITS+3:0]       matrix [9]
);

    // held quaternion is wide enough for the reset value of one
    localparam int QW = (QUAT_FRAC_BITS + 2 > QUAT_WIDTH) ? QUAT_FRAC_BITS + 2 : QUAT_WIDTH;
    localparam int MW = QUAT_FRAC_BITS + 4;
    localparam int PW = 2 * QW;
    localparam int SW = 2 * QW + 3;

    localparam logic signed [QW-1:0] QUAT_ONE = QW'(1) <<< QUAT_FRAC_BITS;
    localparam logic signed [SW-1:0] SUM_ONE  = SW'(1) <<< (2 * QUAT_FRAC_BITS);
    localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (QUAT_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] MAT_MAX  = (SW'(1) <<< (MW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MAT_MIN  = -MAT_MAX - SW'(1);
    localparam logic signed [MW-1:0] MAT_ONE  = MW'(1) <<< QUAT_FRAC_BITS;

    logic signed [QW-1:0]         qx_reg;
    logic signed [QW-1:0]         qy_reg;
    logic signed [QW-1:0]         qz_reg;
    logic signed [QW-1:0]         qw_reg;
    logic signed [QUAT_WIDTH-1:0] wr_val;
    logic                         wr_en;
    logic [REG_IDX_W-1:0]         reg_idx;

    logic signed [PW-1:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_xw, p_yw, p_zw;
    logic signed [SW-1:0] sum [9];
    logic signed [MW-1:0] matrix_next [9];
    logic signed [MW-1:0] matrix_reg  [9];

    assign wr_val  = pwdata[QUAT_WIDTH-1:0];
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];

    // quaternion register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            qw_reg <= QUAT_ONE;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_QUAT_X: qx_reg <= QW'(wr_val);
                REG_QUAT_Y: qy_reg <= QW'(wr_val);
                REG_QUAT_Z: qz_reg <= QW'(wr_val);
                REG_QUAT_W: qw_reg <= QW'(wr_val);
                default:    qx_reg <= qx_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_idx)
            REG_QUAT_X: prdata = APB_DATA_W'(qx_reg);
            REG_QUAT_Y: prdata = APB_DATA_W'(qy_reg);
            REG_QUAT_Z: prdata = APB_DATA_W'(qz_reg);
            REG_QUAT_W: prdata = APB_DATA_W'(qw_reg);
            default:    prdata = '0;
        endcase
    end

    // pairwise component products
    assign p_xx = PW'(qx_reg) * PW'(qx_reg);
    assign p_yy = PW'(qy_reg) * PW'(qy_reg);
    assign p_zz = PW'(qz_reg) * PW'(qz_reg);
    assign p_xy = PW'(qx_reg) * PW'(qy_reg);
    assign p_xz = PW'(qx_reg) * PW'(qz_reg);
    assign p_yz = PW'(qy_reg) * PW'(qz_reg);
    assign p_xw = PW'(qx_reg) * PW'(qw_reg);
    assign p_yw = PW'(qy_reg) * PW'(qw_reg);
    assign p_zw = PW'(qz_reg) * PW'(qw_reg);

    // exact matrix sums, row major
    assign sum[0] = SUM_ONE - ((SW'(p_yy) + SW'(p_zz)) <<< 1);
    assign sum[1] = (SW'(p_xy) - SW'(p_zw)) <<< 1;
    assign sum[2] = (SW'(p_xz) + SW'(p_yw)) <<< 1;
    assign sum[3] = (SW'(p_xy) + SW'(p_zw)) <<< 1;
    assign sum[4] = SUM_ONE - ((SW'(p_xx) + SW'(p_zz)) <<< 1);
    assign sum[5] = (SW'(p_yz) - SW'(p_xw)) <<< 1;
    assign sum[6] = (SW'(p_xz) - SW'(p_yw)) <<< 1;
    assign sum[7] = (SW'(p_yz) + SW'(p_xw)) <<< 1;
    assign sum[8] = SUM_ONE - ((SW'(p_xx) + SW'(p_yy)) <<< 1);

    // round half up and saturate each entry
    always_comb
    begin
        logic signed [SW-1:0] rnd;
        for (int i = 0; i < 9; i++)
        begin
            rnd = (sum[i] + RND_HALF) >>> QUAT_FRAC_BITS;
            if (rnd > MAT_MAX)
                matrix_next[i] = MAT_MAX[MW-1:0];
            else if (rnd < MAT_MIN)
                matrix_next[i] = MAT_MIN[MW-1:0];
            else
                matrix_next[i] = rnd[MW-1:0];
        end
    end

    // matrix register, identity out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                matrix_reg[i] <= (i % 4 == 0) ? MAT_ONE : '0;
        end
        else
        begin
            for (int i = 0; i < 9; i++)
                matrix_reg[i] <= matrix_next[i];
        end
    end

    assign matrix = matrix_reg;

endmodule

// ===== rtl/qpr_datapath.sv =====
// three-stage point rotation pipeline: input, products, round and saturate
module qpr_datapath
    import qpr_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = 14
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [QUAT_FRAC_BITS+3:0]  matrix [9],
    input  logic                              pt_valid,
    output logic                              pt_stall,
    input  pt_beat_t                          pt_beat,
    output logic                              rot_valid,
    input  logic                              rot_stall,
    output rot_beat_t                         rot_beat
);

    localparam int MW = QUAT_FRAC_BITS + 4;
    localparam int PW = MW + COORD_WIDTH;
    localparam int AW = PW + 2;

    localparam logic signed [AW-1:0] RND_HALF = AW'(1) <<< (QUAT_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] C_MAX    = (AW'(1) <<< (COORD_WIDTH - 1)) - AW'(1);
    localparam logic signed [AW-1:0] C_MIN    = -C_MAX - AW'(1);

    logic                          s1_v_reg, s2_v_reg, s3_v_reg;
    logic                          s1_take, s2_take, s3_take;
    pt_beat_t                      pt_reg;
    logic signed [COORD_WIDTH-1:0] coord [3];
    logic signed [PW-1:0]          prod_next [9];
    logic signed [PW-1:0]          prod_reg  [9];
    logic signed [COORD_WIDTH-1:0] rot_c [3];
    logic                          clip_c [3];
    rot_beat_t                     rot_next;
    rot_beat_t                     rot_reg;

    // stage advance: a stage loads when it is empty or its content moves on
    assign s3_take  = !s3_v_reg || !rot_stall;
    assign s2_take  = !s2_v_reg || s3_take;
    assign s1_take  = !s1_v_reg || s2_take;
    assign pt_stall = !s1_take;

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
                s1_v_reg <= pt_valid;
            if (s2_take)
                s2_v_reg <= s1_v_reg;
            if (s3_take)
                s3_v_reg <= s2_v_reg;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (s1_take)
            pt_reg <= pt_beat;
    end

    assign coord[0] = pt_reg.point_x;
    assign coord[1] = pt_reg.point_y;
    assign coord[2] = pt_reg.point_z;

    // nine matrix by coordinate products
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            prod_next[i] = PW'(matrix[i]) * PW'(coord[i % 3]);
    end

    always_ff @(posedge clk)
    begin
        if (s2_take)
        begin
            for (int i = 0; i < 9; i++)
                prod_reg[i] <= prod_next[i];
        end
    end

    // row sums, round half up, saturate to the coordinate range
    always_comb
    begin
        logic signed [AW-1:0] acc;
        for (int r = 0; r < 3; r++)
        begin
            acc = (AW'(prod_reg[3*r]) + AW'(prod_reg[3*r+1]) + AW'(prod_reg[3*r+2])
                   + RND_HALF) >>> QUAT_FRAC_BITS;
            clip_c[r] = 1'b1;
            if (acc > C_MAX)
                rot_c[r] = C_MAX[COORD_WIDTH-1:0];
            else if (acc < C_MIN)
                rot_c[r] = C_MIN[COORD_WIDTH-1:0];
            else
            begin
                rot_c[r]  = acc[COORD_WIDTH-1:0];
                clip_c[r] = 1'b0;
            end
        end
        rot_next.rot_x   = rot_c[0];
        rot_next.rot_y   = rot_c[1];
        rot_next.rot_z   = rot_c[2];
        rot_next.clipped = clip_c[0] || clip_c[1] || clip_c[2];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s3_take)
            rot_reg <= rot_next;
    end

    assign rot_valid = s3_v_reg;
    assign rot_beat  = rot_reg;

endmodule

// ===== rtl/qpr_checker.sv =====
// port-level checker for the quaternion point rotator and its bind
`include "assert_macros.svh"

module qpr_checker
    import qpr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      pt_valid,
    input logic      pt_stall,
    input logic      rot_valid,
    input logic      rot_stall,
    input rot_beat_t rot_beat
);

    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic pt_acc;
    logic at_limit;

    assign pt_acc   = pt_valid && !pt_stall;
    assign at_limit = (rot_beat.rot_x == C_MAX) || (rot_beat.rot_x == C_MIN)
                   || (rot_beat.rot_y == C_MAX) || (rot_beat.rot_y == C_MIN)
                   || (rot_beat.rot_z == C_MAX) || (rot_beat.rot_z == C_MIN);

    // a stalled result beat stays put
    `QPR_ASSERT_NEXT(a_rot_hold, clk, rst_n, rot_valid && rot_stall, rot_valid && $stable(rot_beat))

    // an accepted point is followed by a valid result beat
    `QPR_ASSERT_IMPL(a_latency, clk, rst_n, pt_acc, ##3 rot_valid)

    // input back-pressure only when a result is waiting
    `QPR_ASSERT_IMPL(a_stall_cause, clk, rst_n, pt_stall, rot_valid)

    // saturation flag implies a component at a range limit
    `QPR_ASSERT_IMPL(a_clip_limit, clk, rst_n, rot_valid && rot_beat.clipped, at_limit)

endmodule

bind quaternion_point_rotator_unit qpr_checker u_qpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .rot_valid (rot_valid),
    .rot_stall (rot_stall),
    .rot_beat  (rot_beat)
);
